// ===== rtl/wsa_pkg.sv =====
// wsa_pkg: types, constants and layout functions of the window slot allocator
// no dependencies; imported by wsa_addr and window_slot_allocator

package wsa_pkg;

    // fixed beat layouts
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 176;
    localparam int CFG_ADDR_W  = 3;

    // allocation map row geometry
    localparam int ROW_W  = 32;
    localparam int ROW_SH = 5;

    // register window offset inside the aperture
    localparam logic [63:0] REG_OFFSET = 64'h0000_0000_1fc0_0000;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_BAR_BASE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MODE     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CLASS0   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_CLASS1   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_CLASS2   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_CLASS3   = 3'd5;

    // layout modes
    localparam logic [1:0] MODE_A    = 2'd0;
    localparam logic [1:0] MODE_B    = 2'd1;
    localparam logic [1:0] MODE_NONE = 2'd2;

    localparam logic [1:0] LARGEST_CLASS = 2'd3;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NONE_FREE = 2'd1,
        STAT_INVALID   = 2'd2,
        STAT_UNSUP     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FREE,
        S_ADDR,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [63:0]      bar_base;
        logic [1:0]       mode;
        logic [3:0][32:0] size;
    } cfg_t;

    typedef struct packed {
        logic        ok;
        logic [1:0]  cls;
        logic [7:0]  start;
    } loc_t;

    typedef struct packed {
        logic        done;
        status_t     status;
        logic [32:0] size;
        logic [63:0] win_addr;
        logic [63:0] reg_addr;
    } addr_res_t;

    // windows per class for a layout
    function automatic logic [7:0] class_count(input logic [1:0] mode, input logic [1:0] k);
        logic [7:0] n;
        n = '0;
        unique case (mode)
            MODE_A:
            begin
                unique case (k)
                    2'd0: n = 8'd156;
                    2'd1: n = 8'd10;
                    2'd2: n = 8'd20;
                    2'd3: n = 8'd0;
                endcase
            end
            MODE_B:
            begin
                unique case (k)
                    2'd0: n = 8'd0;
                    2'd1: n = 8'd202;
                    2'd2: n = 8'd0;
                    2'd3: n = 8'd8;
                endcase
            end
            default: n = '0;
        endcase
        return n;
    endfunction

    // first index of a class for a layout
    function automatic logic [7:0] class_start(input logic [1:0] mode, input logic [1:0] k);
        logic [7:0] s;
        s = '0;
        unique case (mode)
            MODE_A:
            begin
                unique case (k)
                    2'd0: s = 8'd0;
                    2'd1: s = 8'd156;
                    2'd2: s = 8'd166;
                    2'd3: s = 8'd186;
                endcase
            end
            MODE_B:
            begin
                unique case (k)
                    2'd0: s = 8'd0;
                    2'd1: s = 8'd0;
                    2'd2: s = 8'd202;
                    2'd3: s = 8'd202;
                endcase
            end
            default: s = '0;
        endcase
        return s;
    endfunction

    // class size, zero when the layout has no windows there
    function automatic logic [32:0] eff_size(input cfg_t cfg, input logic [1:0] k);
        return (class_count(cfg.mode, k) != 8'd0) ? cfg.size[k] : 33'd0;
    endfunction

    // index times register stride
    function automatic logic [11:0] stride_term(input logic [1:0] mode, input logic [7:0] g);
        logic [11:0] t;
        t = '0;
        unique case (mode)
            MODE_A:  t = {1'b0, g, 3'b000};
            MODE_B:  t = {1'b0, g, 3'b000} + {2'b00, g, 2'b00};
            default: t = '0;
        endcase
        return t;
    endfunction

    // class of an index under a layout
    function automatic loc_t locate(input logic [1:0] mode, input logic [7:0] g);
        loc_t r;
        logic [8:0] lo;
        logic [8:0] hi;
        r = '0;
        for (int k = 3; k >= 0; k--)
        begin
            lo = {1'b0, class_start(mode, 2'(k))};
            hi = lo + {1'b0, class_count(mode, 2'(k))};
            if (({1'b0, g} >= lo) && ({1'b0, g} < hi))
            begin
                r.ok    = 1'b1;
                r.cls   = 2'(k);
                r.start = lo[7:0];
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/wsa_ram.sv =====
// wsa_ram: generic single-write, single-read ram with registered read data
// no dependencies; holds the allocation map rows

module wsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/wsa_addr.sv =====
// wsa_addr: window and register address sequencer, one multiply-accumulate per class
// depends on wsa_pkg

module wsa_addr (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [7:0]         g,
    input  wsa_pkg::cfg_t      cfg,
    output wsa_pkg::addr_res_t res
);
    import wsa_pkg::*;

    logic        busy_reg, busy_next;
    logic [2:0]  k_reg, k_next;
    logic        prod_vld_reg, prod_vld_next;
    logic [1:0]  cls_reg;
    logic [7:0]  off_reg;
    logic [40:0] prod_reg;
    logic [63:0] acc_reg;
    logic [63:0] reg_addr_reg;

    loc_t        loc;
    logic        issue;
    logic        done;
    logic        unsup;
    logic [7:0]  mul_a;
    logic [32:0] mul_b;

    // class of the window being reported
    assign loc = locate(cfg.mode, g);

    // one product per class up to and including the window's own class
    assign issue = busy_reg && (k_reg <= {1'b0, cls_reg});
    assign done  = busy_reg && !issue && !prod_vld_reg;
    assign mul_a = (k_reg[1:0] < cls_reg) ? class_count(cfg.mode, k_reg[1:0]) : off_reg;
    assign mul_b = eff_size(cfg, k_reg[1:0]);

    // sequencer control
    always_comb
    begin
        busy_next     = busy_reg;
        k_next        = k_reg;
        prod_vld_next = prod_vld_reg;
        if (start)
        begin
            busy_next     = 1'b1;
            k_next        = '0;
            prod_vld_next = 1'b0;
        end
        else if (busy_reg)
        begin
            prod_vld_next = issue;
            if (issue)
            begin
                k_next = k_reg + 3'd1;
            end
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            k_reg        <= '0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            k_reg        <= k_next;
            prod_vld_reg <= prod_vld_next;
        end
    end

    // multiply stage and accumulator
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cls_reg      <= loc.cls;
            off_reg      <= g - loc.start;
            acc_reg      <= cfg.bar_base;
            reg_addr_reg <= cfg.bar_base + REG_OFFSET + 64'(stride_term(cfg.mode, g));
        end
        else
        begin
            if (issue)
            begin
                prod_reg <= 41'(mul_a) * 41'(mul_b);
            end
            if (prod_vld_reg)
            begin
                acc_reg <= acc_reg + 64'(prod_reg);
            end
        end
    end

    // result fields
    assign unsup = (cfg.mode == MODE_B) && (cls_reg == LARGEST_CLASS);

    always_comb
    begin
        res.done     = done;
        res.status   = unsup ? STAT_UNSUP : STAT_OK;
        res.size     = eff_size(cfg, cls_reg);
        res.win_addr = unsup ? 64'd0 : acc_reg;
        res.reg_addr = reg_addr_reg;
    end

endmodule

// ===== rtl/window_slot_allocator.sv =====
// window_slot_allocator: top level, command sequencer and allocation map control
// depends on wsa_pkg, wsa_ram and wsa_addr
//
// channel   dir  handshake          payload (lowest bits first)
// s_*       in   s_tvalid/s_tready  tuser: cmd; tdata: request_size, entry_index
// m_*       out  m_tvalid/m_tready  tuser: status; tdata: granted_index, window_size,
//                                   window_address, reg_address
// cfg_*     in   cfg_we             cfg_addr register index, cfg_wdata value
//
// one command at a time through a map ram of 32-bit rows, one row read per scan cycle
// path from accept to result valid: allocate scan, address, output; nothing free
// scan, output; free command free, address, output; query address, output; invalid
// or unused command output; the address state runs the multiply-accumulate in wsa_addr
// reset clears a per-row valid flag, so no clearing pass is needed
// a result waiting on m_tready stalls the block only when the next one is finished

module window_slot_allocator #(
    parameter int MAX_WINDOWS = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [wsa_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [63:0]                        cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [wsa_pkg::IN_TDATA_W-1:0]     s_tdata,   // request_size, entry_index
    input  logic [1:0]                         s_tuser,   // cmd
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [wsa_pkg::OUT_TDATA_W-1:0]    m_tdata,   // granted_index, window_size,
                                                          // window_address, reg_address
    output logic [1:0]                         m_tuser    // status
);
    import wsa_pkg::*;

    localparam int ROWS  = (MAX_WINDOWS + ROW_W - 1) / ROW_W;
    localparam int RAW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int GIW   = RAW + ROW_SH;
    localparam int CMP_W = GIW + 8;

    // configuration registers
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bar_base <= '0;
            cfg_reg.mode     <= MODE_NONE;
            cfg_reg.size     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_BAR_BASE: cfg_reg.bar_base <= cfg_wdata;
                CFG_MODE:     cfg_reg.mode     <= cfg_wdata[1:0];
                CFG_CLASS0:   cfg_reg.size[0]  <= cfg_wdata[32:0];
                CFG_CLASS1:   cfg_reg.size[1]  <= cfg_wdata[32:0];
                CFG_CLASS2:   cfg_reg.size[2]  <= cfg_wdata[32:0];
                CFG_CLASS3:   cfg_reg.size[3]  <= cfg_wdata[32:0];
                default:      ;
            endcase
        end
    end

    // state and working registers
    state_t            state_reg, state_next;
    logic [32:0]       req_reg;
    logic [7:0]        idx_reg;
    logic [RAW-1:0]    cur_row_reg, cur_row_next;
    logic [ROWS-1:0]   row_vld_reg;

    logic              m_valid_reg;
    status_t           pend_status_reg;
    logic [7:0]        pend_idx_reg;
    logic [32:0]       pend_size_reg;
    logic [63:0]       pend_waddr_reg;
    logic [63:0]       pend_raddr_reg;
    status_t           out_status_reg;
    logic [7:0]        out_idx_reg;
    logic [32:0]       out_size_reg;
    logic [63:0]       out_waddr_reg;
    logic [63:0]       out_raddr_reg;

    // input beat fields
    logic              in_acc;
    cmd_t              in_cmd;
    logic [32:0]       in_req;
    logic [7:0]        in_idx;
    loc_t              in_loc;
    logic              in_ok;

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign in_cmd   = cmd_t'(s_tuser);
    assign in_req   = s_tdata[32:0];
    assign in_idx   = s_tdata[40:33];
    assign in_loc   = locate(cfg_reg.mode, in_idx);
    assign in_ok    = in_loc.ok && (32'(in_idx) < MAX_WINDOWS);

    // map ram
    logic              rd_en;
    logic [RAW-1:0]    rd_addr;
    logic [ROW_W-1:0]  rd_data;
    logic              wr_en;
    logic [RAW-1:0]    wr_addr;
    logic [ROW_W-1:0]  wr_data;

    wsa_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // address sequencer
    logic              au_start;
    logic [7:0]        au_g;
    addr_res_t         au_res;

    wsa_addr u_addr (
        .clk   (clk),
        .rst_n (rst_n),
        .start (au_start),
        .g     (au_g),
        .cfg   (cfg_reg),
        .res   (au_res)
    );

    // row as stored; a row never written reads as all free
    logic [ROW_W-1:0]  row_q;
    assign row_q = row_vld_reg[cur_row_reg] ? rd_data : '0;

    // classes that satisfy the request, and their index ranges
    logic [3:0]             fit;
    logic [3:0][CMP_W-1:0]  cls_lo;
    logic [3:0][CMP_W-1:0]  cls_hi;
    logic [CMP_W-1:0]       end3;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            fit[k] = (eff_size(cfg_reg, 2'(k)) != 33'd0) &&
                     ((req_reg == 33'd0) || (req_reg <= eff_size(cfg_reg, 2'(k))));
            cls_lo[k] = CMP_W'(class_start(cfg_reg.mode, 2'(k)));
            cls_hi[k] = CMP_W'(class_start(cfg_reg.mode, 2'(k)))
                      + CMP_W'(class_count(cfg_reg.mode, 2'(k)));
        end
    end

    assign end3 = cls_hi[3];

    // eligible and free bits of the current row
    logic [ROW_W-1:0]  elig;
    logic [ROW_W-1:0]  free_v;
    logic              hit;
    logic [ROW_SH-1:0] hit_bit;
    logic [7:0]        hit_g;
    logic [CMP_W-1:0]  next_base;
    logic              more_rows;
    logic              any_fit;

    always_comb
    begin
        logic [CMP_W-1:0] gw;
        logic             in_fit;
        for (int j = 0; j < ROW_W; j++)
        begin
            gw     = CMP_W'({cur_row_reg, ROW_SH'(j)});
            in_fit = 1'b0;
            for (int k = 0; k < 4; k++)
            begin
                if (fit[k] && (gw >= cls_lo[k]) && (gw < cls_hi[k]))
                begin
                    in_fit = 1'b1;
                end
            end
            elig[j] = in_fit && (gw < CMP_W'(MAX_WINDOWS));
        end
    end

    assign free_v = ~row_q & elig;
    assign hit    = |free_v;

    // lowest free eligible bit
    always_comb
    begin
        hit_bit = '0;
        for (int j = ROW_W - 1; j >= 0; j--)
        begin
            if (free_v[j])
            begin
                hit_bit = ROW_SH'(j);
            end
        end
    end

    assign hit_g     = 8'({cur_row_reg, hit_bit});
    assign next_base = (CMP_W'(cur_row_reg) + CMP_W'(1)) << ROW_SH;
    assign more_rows = (cur_row_reg != RAW'(ROWS - 1)) && (next_base < end3);
    assign any_fit   = |fit;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    priority if (in_cmd == CMD_ALLOC)
                        state_next = S_SCAN;
                    else if ((in_cmd == CMD_FREE) && in_ok)
                        state_next = S_FREE;
                    else if ((in_cmd == CMD_QUERY) && in_ok)
                        state_next = S_ADDR;
                    else
                        state_next = S_OUT;
                end
            end
            S_SCAN:
            begin
                priority if (!any_fit)
                    state_next = S_OUT;
                else if (hit)
                    state_next = S_ADDR;
                else if (more_rows)
                    state_next = S_SCAN;
                else
                    state_next = S_OUT;
            end
            S_FREE:
            begin
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                if (au_res.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state outputs
    logic pend_load_inv;
    logic pend_load_none;
    logic pend_load_au;
    logic out_load;

    always_comb
    begin
        rd_en          = 1'b0;
        rd_addr        = cur_row_reg;
        wr_en          = 1'b0;
        wr_addr        = cur_row_reg;
        wr_data        = row_q;
        au_start       = 1'b0;
        au_g           = idx_reg;
        cur_row_next   = cur_row_reg;
        pend_load_inv  = 1'b0;
        pend_load_none = 1'b0;
        pend_load_au   = 1'b0;
        out_load       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = (in_cmd == CMD_ALLOC) ? '0 : RAW'(in_idx >> ROW_SH);
                    cur_row_next = rd_addr;
                    if ((in_cmd == CMD_QUERY) && in_ok)
                    begin
                        au_start = 1'b1;
                        au_g     = in_idx;
                    end
                    if ((in_cmd != CMD_ALLOC) &&
                        !(((in_cmd == CMD_FREE) || (in_cmd == CMD_QUERY)) && in_ok))
                    begin
                        pend_load_inv = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                priority if (!any_fit)
                begin
                    pend_load_none = 1'b1;
                end
                else if (hit)
                begin
                    wr_en    = 1'b1;
                    wr_data  = row_q | (ROW_W'(1) << hit_bit);
                    au_start = 1'b1;
                    au_g     = hit_g;
                end
                else if (more_rows)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = cur_row_reg + RAW'(1);
                    cur_row_next = rd_addr;
                end
                else
                begin
                    pend_load_none = 1'b1;
                end
            end
            S_FREE:
            begin
                wr_en    = 1'b1;
                wr_data  = row_q & ~(ROW_W'(1) << idx_reg[ROW_SH-1:0]);
                au_start = 1'b1;
                au_g     = idx_reg;
            end
            S_ADDR:
            begin
                pend_load_au = au_res.done;
            end
            S_OUT:
            begin
                out_load = !m_valid_reg || m_tready;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cur_row_reg <= '0;
            row_vld_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_row_reg <= cur_row_next;
            if (wr_en)
            begin
                row_vld_reg[wr_addr] <= 1'b1;
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // command, pending result and output registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            req_reg <= in_req;
            idx_reg <= in_idx;
        end
        if (au_start)
        begin
            pend_idx_reg <= au_g;
        end
        if (pend_load_inv)
        begin
            pend_status_reg <= STAT_INVALID;
            pend_idx_reg    <= in_idx;
            pend_size_reg   <= '0;
            pend_waddr_reg  <= '0;
            pend_raddr_reg  <= '0;
        end
        if (pend_load_none)
        begin
            pend_status_reg <= STAT_NONE_FREE;
            pend_idx_reg    <= '0;
            pend_size_reg   <= '0;
            pend_waddr_reg  <= '0;
            pend_raddr_reg  <= '0;
        end
        if (pend_load_au)
        begin
            pend_status_reg <= au_res.status;
            pend_size_reg   <= au_res.size;
            pend_waddr_reg  <= au_res.win_addr;
            pend_raddr_reg  <= au_res.reg_addr;
        end
        if (out_load)
        begin
            out_status_reg <= pend_status_reg;
            out_idx_reg    <= pend_idx_reg;
            out_size_reg   <= pend_size_reg;
            out_waddr_reg  <= pend_waddr_reg;
            out_raddr_reg  <= pend_raddr_reg;
        end
    end

    // output beat
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'b0, out_raddr_reg, out_waddr_reg, out_size_reg, out_idx_reg};

`ifndef SYNTHESIS
    a_done_in_addr: assert property (@(posedge clk) disable iff (!rst_n)
        au_res.done |-> (state_reg == S_ADDR))
        else $error("address sequencer finished outside the address state");

    a_scan_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> $past(rd_en))
        else $error("map row scanned without a preceding read");

    a_free_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FREE) |-> ($past(rd_en) && ($past(rd_addr) == cur_row_reg)))
        else $error("free writes back a row that was not read");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (m_tvalid && (m_tuser == $past(pend_status_reg))))
        else $error("result not presented after output load");
`endif

endmodule
